// ----- design/byte_ring_fifo_core_assert.svh -----
// Assertion macros shared by the byte ring FIFO checkers.
// Depends on nothing; take it in with a plain include.
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/brf_pkg.sv -----
// Shared codes for the byte ring FIFO: action and status encodings.
// No dependencies; used by the core and its checker.
package brf_pkg;

    localparam logic [2:0] ACT_PUSH     = 3'd0;
    localparam logic [2:0] ACT_POP      = 3'd1;
    localparam logic [2:0] ACT_PEEK     = 3'd2;
    localparam logic [2:0] ACT_POP_RUN  = 3'd3;
    localparam logic [2:0] ACT_PEEK_RUN = 3'd4;
    localparam logic [2:0] ACT_SKIP_RUN = 3'd5;
    localparam logic [2:0] ACT_CLEAR    = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam int unsigned CAP_WIDTH = 9;

    typedef logic [CAP_WIDTH-1:0] t_cap;
    typedef logic [7:0]           t_count;

endpackage

// ----- design/brf_ram.sv -----
// Byte store of the ring FIFO: one write port, one read port, registered read data.
// Standalone; no package needed.
module brf_ram #(
    parameter int ENTRIES = 256,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [ENTRIES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/byte_ring_fifo_core.sv -----
// Byte ring FIFO top level: control, indices, counts and result register.
// Depends on brf_pkg and brf_ram.
//
// A byte ring over a store of min(DEPTH,256) bytes, of which the configured capacity is in
// use (clamped to 2..min(DEPTH,256)); it holds at most capacity minus one bytes. Writing the
// capacity empties the ring. Push, skip, clear and every error or busy request are taken one
// per cycle while the output side keeps up, each answered by one result. Pop and peek
// requests read the store through its single read port with registered data: a request
// starts the read when it is accepted, then delivers one byte per cycle while the output
// side keeps up, and no new request is taken until its last byte has gone out. The store
// holds no reset value and needs no clearing pass; only bytes that were pushed are ever read.
// Every result carries the fill and free counts as they stand after the whole request.
module byte_ring_fifo_core #(
    parameter int DEPTH   = 256,
    parameter int MAX_RUN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  brf_pkg::t_cap     i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_byte_in,
    input  logic [6:0]        i_run_length,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_byte_out,
    output logic [1:0]        o_status,
    output logic              o_last,
    output brf_pkg::t_count   o_fill_count,
    output brf_pkg::t_count   o_free_count
);
    import brf_pkg::*;

    localparam int STORE_DEPTH = (DEPTH < 256) ? DEPTH : 256;
    localparam int IW          = $clog2(STORE_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_OUT  = 1'b1;

    typedef logic [IW-1:0] t_idx;

    function automatic t_idx wrap_add(t_idx idx, t_count inc, t_cap cap);
        t_cap sum;
        sum = t_cap'(idx) + t_cap'(inc);
        if (sum >= cap) begin
            sum = sum - cap;
        end
        return sum[IW-1:0];
    endfunction

    logic       r_state, n_state;
    t_cap       r_cap;
    t_idx       r_rd_idx, n_rd_idx;
    t_idx       r_wr_idx, n_wr_idx;
    t_count     r_held, n_held;
    t_idx       r_addr, n_addr;
    logic [6:0] r_left, n_left;

    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic [1:0] r_o_status;
    logic       r_o_last;
    t_count     r_o_fill;
    t_count     r_o_free;

    logic       slot_free;
    logic       accept;
    logic       load_out;
    logic [7:0] ld_byte;
    logic [1:0] ld_status;
    logic       ld_last;
    t_count     ld_fill;

    logic       ram_we;
    t_idx       ram_waddr;
    logic       ram_re;
    t_idx       ram_raddr;
    logic [7:0] ram_rdata;

    t_cap       cfg_cap;
    logic       run_too_long;

    assign slot_free = !r_o_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || !slot_free;
    assign accept    = i_valid && !o_stall;

    assign run_too_long = (i_run_length > 7'(MAX_RUN)) || ({1'b0, i_run_length} > r_held);

    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_held    = r_held;
        n_addr    = r_addr;
        n_left    = r_left;
        load_out  = 1'b0;
        ld_byte   = 8'd0;
        ld_status = ST_OK;
        ld_last   = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_wr_idx;
        ram_re    = 1'b0;
        ram_raddr = r_rd_idx;

        if (r_state == S_IDLE) begin
            if (accept) begin
                load_out = 1'b1;
                unique case (i_action)
                    ACT_PUSH: begin
                        if ((t_cap'(r_held) + t_cap'(1)) >= r_cap) begin
                            ld_status = ST_ERR;
                        end else begin
                            ram_we   = 1'b1;
                            n_wr_idx = wrap_add(r_wr_idx, t_count'(1), r_cap);
                            n_held   = r_held + t_count'(1);
                        end
                    end
                    ACT_POP, ACT_PEEK: begin
                        if (r_held == t_count'(0)) begin
                            ld_status = ST_ERR;
                        end else begin
                            // result leaves from the read state once the byte is back
                            load_out = 1'b0;
                            ram_re   = 1'b1;
                            n_addr   = wrap_add(r_rd_idx, t_count'(1), r_cap);
                            n_left   = 7'd1;
                            n_state  = S_OUT;
                            if (i_action == ACT_POP) begin
                                n_rd_idx = wrap_add(r_rd_idx, t_count'(1), r_cap);
                                n_held   = r_held - t_count'(1);
                            end
                        end
                    end
                    ACT_POP_RUN, ACT_PEEK_RUN, ACT_SKIP_RUN: begin
                        if (i_run_length == 7'd0) begin
                            ld_status = ST_BUSY;
                        end else if (run_too_long) begin
                            ld_status = ST_ERR;
                        end else if (i_action == ACT_SKIP_RUN) begin
                            n_rd_idx = wrap_add(r_rd_idx, t_count'(i_run_length), r_cap);
                            n_held   = r_held - t_count'(i_run_length);
                        end else begin
                            load_out = 1'b0;
                            ram_re   = 1'b1;
                            n_addr   = wrap_add(r_rd_idx, t_count'(1), r_cap);
                            n_left   = i_run_length;
                            n_state  = S_OUT;
                            if (i_action == ACT_POP_RUN) begin
                                n_rd_idx = wrap_add(r_rd_idx, t_count'(i_run_length), r_cap);
                                n_held   = r_held - t_count'(i_run_length);
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        n_rd_idx = '0;
                        n_wr_idx = '0;
                        n_held   = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            if (slot_free) begin
                load_out = 1'b1;
                ld_byte  = ram_rdata;
                ld_last  = (r_left == 7'd1);
                if (r_left == 7'd1) begin
                    n_state = S_IDLE;
                end else begin
                    // fetch the next byte while this one goes out
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_addr    = wrap_add(r_addr, t_count'(1), r_cap);
                    n_left    = r_left - 7'd1;
                end
            end
        end
        ld_fill = n_held;
    end

    always_comb begin
        cfg_cap = i_cfg_data;
        if (i_cfg_data < t_cap'(2)) begin
            cfg_cap = t_cap'(2);
        end else if (i_cfg_data > t_cap'(STORE_DEPTH)) begin
            cfg_cap = t_cap'(STORE_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= t_cap'(STORE_DEPTH);
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_held   <= '0;
            r_addr   <= '0;
            r_left   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_cap    <= cfg_cap;
                r_rd_idx <= '0;
                r_wr_idx <= '0;
                r_held   <= '0;
            end else begin
                r_rd_idx <= n_rd_idx;
                r_wr_idx <= n_wr_idx;
                r_held   <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_byte   <= ld_byte;
            r_o_status <= ld_status;
            r_o_last   <= ld_last;
            r_o_fill   <= ld_fill;
            r_o_free   <= t_count'(r_cap - t_cap'(1) - t_cap'(ld_fill));
        end
    end

    brf_ram #(
        .ENTRIES(STORE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_byte_in),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_valid      = r_o_valid;
    assign o_byte_out   = r_o_byte;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;
    assign o_fill_count = r_o_fill;
    assign o_free_count = r_o_free;

endmodule

// ----- design/brf_checker.sv -----
// Port-level checker for the byte ring FIFO core, attached by bind.
// Depends on brf_pkg and byte_ring_fifo_core_assert.svh.
`include "byte_ring_fifo_core_assert.svh"

module brf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [7:0]        o_byte_out,
    input logic [1:0]        o_status,
    input logic              o_last,
    input brf_pkg::t_count   o_fill_count,
    input brf_pkg::t_count   o_free_count
);
    import brf_pkg::*;

    // error and busy answers close their request at once
    `BRF_ASSERT_NOW(a_fail_is_last, i_clk, i_rst_n,
        o_valid && (o_status != ST_OK), o_last,
        "error or busy result not marked last")

    `BRF_ASSERT_NOW(a_fail_no_byte, i_clk, i_rst_n,
        o_valid && (o_status != ST_OK), o_byte_out == 8'd0,
        "error or busy result carries a byte")

    `BRF_ASSERT_NOW(a_count_sum, i_clk, i_rst_n,
        o_valid, ({1'b0, o_fill_count} + {1'b0, o_free_count}) <= 9'd255,
        "fill plus free exceeds the ring")

    // a held result leaves no room for a new request
    `BRF_ASSERT_NOW(a_full_stalls_input, i_clk, i_rst_n,
        o_valid && i_stall, o_stall,
        "input accepted while the result register is held")

    `BRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall,
        o_valid && $stable(o_byte_out) && $stable(o_status) && $stable(o_last)
            && $stable(o_fill_count) && $stable(o_free_count),
        "stalled result changed")

endmodule

bind byte_ring_fifo_core brf_checker u_brf_checker (.*);
